// ===== rtl/ffaa_pkg.sv =====
// Package with types and constants for the first-fit arena allocator.
`default_nettype none
package ffaa_pkg;
    localparam int ARENA_BYTES  = 256;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 16;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W = $clog2(ARENA_BYTES + 1);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] request_size;
        logic [7:0] free_offset;
    } ffaa_in_t;

    typedef struct packed {
        logic [7:0] data_offset;
        logic       failed;
    } ffaa_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_FREE,
        ST_DONE
    } ffaa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic do_alloc;
        logic do_free;
        logic respond;
    } ffaa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic last;
        logic mode;
    } ffaa_stat_t;
endpackage
`default_nettype wire

// ===== rtl/ffaa_ctrl.sv =====
// Controller state machine of the first-fit arena allocator.
`default_nettype none
module ffaa_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    output ffaa_pkg::ffaa_cmd_t  cmd,
    input  ffaa_pkg::ffaa_stat_t stat
);
    import ffaa_pkg::*;

    ffaa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.hit)
                    state_next = (stat.mode == MODE_FREE) ? ST_FREE : ST_ALLOC;
                else if (stat.last)
                    state_next = ST_DONE;
            end
            ST_ALLOC: state_next = ST_DONE;
            ST_FREE:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:  cmd.load = start;
            ST_SCAN:  cmd.step = !stat.hit && !stat.last;
            ST_ALLOC: cmd.do_alloc = 1'b1;
            ST_FREE:  cmd.do_free = 1'b1;
            ST_DONE:  cmd.respond = 1'b1;
            default:  cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.do_alloc, cmd.do_free, cmd.respond}))
        else $error("more than one command");
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_alloc || cmd.do_free) |=> cmd.respond)
        else $error("update not followed by response");
    a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> !busy)
        else $error("busy after response");
`endif
endmodule
`default_nettype wire

// ===== rtl/ffaa_datapath.sv =====
// Block table and scan datapath of the first-fit arena allocator.
`default_nettype none
module ffaa_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ffaa_pkg::ffaa_in_t   item,
    input  ffaa_pkg::ffaa_cmd_t  cmd,
    output ffaa_pkg::ffaa_stat_t stat,
    output ffaa_pkg::ffaa_out_t  result,
    output logic                 result_valid
);
    import ffaa_pkg::*;

    logic [OFF_W-1:0] off_reg [MAX_BLOCKS];
    logic [OFF_W-1:0] len_reg [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] use_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    ffaa_in_t item_reg;
    ffaa_out_t res_reg;

    logic [OFF_W-1:0] cur_off, cur_len, req_ext, foff_ext, rest, end_i;
    logic hit_alloc, hit_free, last;
    logic prev_free, next_free, has_next, has_prev;
    logic [CNT_W-1:0] idx_ext;

    assign idx_ext  = CNT_W'(idx_reg);
    assign cur_off  = off_reg[idx_reg];
    assign cur_len  = len_reg[idx_reg];
    assign req_ext  = OFF_W'(item_reg.request_size);
    assign foff_ext = OFF_W'(item_reg.free_offset);
    assign rest     = cur_len - req_ext;
    assign hit_alloc = !use_reg[idx_reg] && (req_ext <= cur_len);
    assign hit_free  = use_reg[idx_reg] &&
                       (OFF_W'(cur_off + OFF_W'(HEADER_BYTES)) == foff_ext);
    assign last = (idx_ext + CNT_W'(1) >= count_reg);
    assign has_next = (idx_ext + CNT_W'(2) < count_reg) ? 1'b1 : 1'b0;
    assign has_prev = (idx_reg != '0);
    assign next_free = (idx_ext + CNT_W'(1) < count_reg) && !use_reg[IDX_W'(idx_reg + 1'b1)];
    assign prev_free = has_prev && !use_reg[IDX_W'(idx_reg - 1'b1)];

    assign stat.hit  = (item_reg.mode == MODE_FREE) ? hit_free : hit_alloc;
    assign stat.last = last;
    assign stat.mode = item_reg.mode;

    // End of the data span once the free merges are done.
    always_comb begin
        if (next_free)
            end_i = has_next ? off_reg[IDX_W'(idx_reg + 2'd2)] : OFF_W'(ARENA_BYTES);
        else
            end_i = (idx_ext + CNT_W'(1) < count_reg) ?
                    off_reg[IDX_W'(idx_reg + 1'b1)] : OFF_W'(ARENA_BYTES);
    end

    logic [OFF_W-1:0] base_off, span;
    logic [IDX_W-1:0] tgt;
    assign tgt      = prev_free ? IDX_W'(idx_reg - 1'b1) : idx_reg;
    assign base_off = off_reg[tgt] + OFF_W'(HEADER_BYTES);
    assign span     = (end_i > base_off) ? end_i - base_off : '0;

    logic split;
    logic [CNT_W-1:0] rm;
    assign split = (rest >= OFF_W'(HEADER_BYTES)) && (count_reg < CNT_W'(MAX_BLOCKS));
    assign rm = CNT_W'(next_free) + CNT_W'(prev_free);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_BLOCKS; k++)
            begin
                off_reg[k] <= '0;
                len_reg[k] <= (k == 0) ? OFF_W'(ARENA_BYTES - HEADER_BYTES) : '0;
            end
            use_reg      <= '0;
            count_reg    <= CNT_W'(1);
            idx_reg      <= '0;
            item_reg     <= '0;
            res_reg      <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.respond;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                item_reg <= item;
                res_reg  <= '{data_offset: 8'd0, failed: (item.mode == MODE_ALLOC)};
            end
            if (cmd.step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.do_alloc)
            begin
                use_reg[idx_reg] <= 1'b1;
                res_reg <= '{data_offset: 8'(cur_off + OFF_W'(HEADER_BYTES)), failed: 1'b0};
                if (split)
                begin
                    for (int k = 1; k < MAX_BLOCKS; k++)
                    begin
                        if (k > int'(idx_reg) + 1)
                        begin
                            off_reg[k] <= off_reg[k-1];
                            len_reg[k] <= len_reg[k-1];
                            use_reg[k] <= use_reg[k-1];
                        end
                        else if (k == int'(idx_reg) + 1)
                        begin
                            off_reg[k] <= cur_off + OFF_W'(HEADER_BYTES) + req_ext;
                            len_reg[k] <= rest - OFF_W'(HEADER_BYTES);
                            use_reg[k] <= 1'b0;
                        end
                    end
                    len_reg[idx_reg] <= req_ext;
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.do_free)
            begin
                // Compact: the merged block lands at tgt, later entries shift by rm.
                for (int k = 0; k < MAX_BLOCKS; k++)
                begin
                    if (k > int'(tgt))
                    begin
                        if (k + int'(rm) < MAX_BLOCKS && k + int'(rm) < int'(count_reg))
                        begin
                            off_reg[k] <= off_reg[k + int'(rm)];
                            len_reg[k] <= len_reg[k + int'(rm)];
                            use_reg[k] <= use_reg[k + int'(rm)];
                        end
                        else
                        begin
                            off_reg[k] <= '0;
                            len_reg[k] <= '0;
                            use_reg[k] <= 1'b0;
                        end
                    end
                end
                use_reg[tgt] <= 1'b0;
                len_reg[tgt] <= span;
                count_reg <= count_reg - rm;
            end
        end
    end

    assign result = res_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");
    a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_alloc && split) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("split did not add a block");
    a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && item_reg.mode == MODE_FREE |-> !result.failed)
        else $error("free reported failure");
`endif
endmodule
`default_nettype wire

// ===== rtl/first_fit_arena_allocator_unit.sv =====
// Top level of the first-fit arena allocator.
`default_nettype none
// First-fit arena allocator with coalescing of freed blocks.
// Command channel: an item (mode, request_size, free_offset) transfers at a
// rising edge where start is high and busy is low. busy falls in the cycle
// that shows the result, so the next item can transfer at the edge ending it.
// Result channel: data_offset and failed appear for exactly one cycle with
// done high. The receiver cannot stall this channel, so no result waits.
// Scan: an item walks the block table one entry per cycle in the SCAN state.
// On a match the controller passes through ALLOC or FREE and then DONE; when
// no block matches, it goes from the last entry straight to DONE. done is
// registered from the respond command of DONE. A new item is taken only once
// the controller is back in IDLE, so items never overlap in the block.
// An allocate splits the chosen block when the rest can hold a header and
// the table has room; a free merges with available neighbors in the FREE state.
// Reset: one available block spanning the arena minus one header; the
// block is idle immediately after reset is released.
module first_fit_arena_allocator_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  ffaa_pkg::ffaa_in_t  item,
    output ffaa_pkg::ffaa_out_t result,
    output logic                done
);
    import ffaa_pkg::*;

    ffaa_cmd_t  cmd;
    ffaa_stat_t stat;

    ffaa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    ffaa_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (done)
    );

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without item");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.failed) |-> result.data_offset == 8'd0)
        else $error("failed result carries offset");
`endif
endmodule
`default_nettype wire

// ===== verif/first_fit_arena_allocator_unit_tb.sv =====
// Self-checking testbench for the first-fit arena allocator top level.
`default_nettype none
module first_fit_arena_allocator_unit_tb;
    import ffaa_pkg::*;

    // Clock, reset and the ports of the block.
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    ffaa_in_t  item = '0;
    ffaa_out_t result;
    logic      done;

    first_fit_arena_allocator_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .done   (done)
    );

    always #2 clk = ~clk;

    // Shadow copy of the block table. Offsets are kept as plain integers so
    // that an offset of the arena end does not wrap before it is truncated.
    int unsigned arena_off  [MAX_BLOCKS];
    int unsigned arena_len  [MAX_BLOCKS];
    bit          arena_used [MAX_BLOCKS];
    int unsigned arena_cnt;

    // Results owed by the block, oldest first.
    ffaa_out_t   owed_results[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned alloc_sent = 0;
    int unsigned alloc_refused = 0;
    int unsigned free_sent = 0;
    int unsigned table_full_seen = 0;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // Bring the shadow table to its state after reset.
    task automatic table_reset();
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            arena_off[k]  = 0;
            arena_len[k]  = 0;
            arena_used[k] = 1'b0;
        end
        arena_len[0] = ARENA_BYTES - HEADER_BYTES;
        arena_cnt    = 1;
    endtask

    // Remove one table entry and close the gap it leaves.
    task automatic table_drop(input int unsigned idx);
        for (int unsigned k = idx; k + 1 < arena_cnt; k++)
        begin
            arena_off[k]  = arena_off[k + 1];
            arena_len[k]  = arena_len[k + 1];
            arena_used[k] = arena_used[k + 1];
        end
        arena_cnt--;
        arena_off[arena_cnt]  = 0;
        arena_len[arena_cnt]  = 0;
        arena_used[arena_cnt] = 1'b0;
    endtask

    // Work out the answer to one command and update the shadow table the way
    // the block updates its own.
    task automatic arena_predict(input ffaa_in_t cmd_item, output ffaa_out_t answer);
        int unsigned size;
        int unsigned rest;
        int unsigned idx;
        int unsigned data_end;
        bit          found;
        answer = '0;
        found  = 1'b0;
        if (cmd_item.mode == MODE_ALLOC)
        begin
            size = cmd_item.request_size;
            // First fit: the lowest addressed available block that is large enough.
            for (int unsigned i = 0; i < arena_cnt && !found; i++)
            begin
                if (!arena_used[i] && size <= arena_len[i])
                begin
                    found = 1'b1;
                    rest  = arena_len[i] - size;
                    arena_used[i] = 1'b1;
                    if (rest >= HEADER_BYTES && arena_cnt < MAX_BLOCKS)
                    begin
                        // Split the rest off as a new available block.
                        for (int unsigned k = arena_cnt; k > i + 1; k--)
                        begin
                            arena_off[k]  = arena_off[k - 1];
                            arena_len[k]  = arena_len[k - 1];
                            arena_used[k] = arena_used[k - 1];
                        end
                        arena_off[i + 1]  = arena_off[i] + HEADER_BYTES + size;
                        arena_len[i + 1]  = rest - HEADER_BYTES;
                        arena_used[i + 1] = 1'b0;
                        arena_cnt++;
                        arena_len[i] = size;
                    end
                    else if (rest >= HEADER_BYTES)
                    begin
                        table_full_seen++;
                    end
                    answer.data_offset = 8'(arena_off[i] + HEADER_BYTES);
                end
            end
            answer.failed = !found;
        end
        else
        begin
            for (int unsigned i = 0; i < arena_cnt && !found; i++)
            begin
                if (arena_used[i] && arena_off[i] + HEADER_BYTES == cmd_item.free_offset)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            // An offset that names no used block leaves the table alone.
            if (found)
            begin
                arena_used[idx] = 1'b0;
                if (idx + 1 < arena_cnt && !arena_used[idx + 1])
                    table_drop(idx + 1);
                if (idx > 0 && !arena_used[idx - 1])
                begin
                    table_drop(idx);
                    idx--;
                end
                // The merged block spans up to the next header or the arena end.
                data_end = (idx + 1 < arena_cnt) ? arena_off[idx + 1] : ARENA_BYTES;
                arena_len[idx] = (data_end > arena_off[idx] + HEADER_BYTES) ?
                                 data_end - arena_off[idx] - HEADER_BYTES : 0;
            end
        end
    endtask

    // Data offset of a randomly chosen used block, or a random offset when
    // nothing is allocated.
    function automatic logic [7:0] pick_live_offset();
        int unsigned live[$];
        for (int unsigned i = 0; i < arena_cnt; i++)
            if (arena_used[i])
                live.push_back(arena_off[i] + HEADER_BYTES);
        if (live.size() == 0)
            return 8'($urandom);
        return 8'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    // Offer one command and hold it until the block takes it. The command is
    // driven at the falling edge; busy only moves at rising edges, so its value
    // here is the one the next rising edge sees. start is left high so that
    // a back-to-back command is not lowered and raised in one step.
    task automatic send_command(input logic op, input logic [7:0] size,
                                input logic [7:0] offset);
        ffaa_in_t  next_item;
        ffaa_out_t answer;
        next_item.mode         = op;
        next_item.request_size = size;
        next_item.free_offset  = offset;
        @(negedge clk);
        start = 1'b1;
        item  = next_item;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        arena_predict(next_item, answer);
        owed_results.push_back(answer);
        if (op == MODE_ALLOC)
            alloc_sent++;
        else
            free_sent++;
        if (answer.failed)
            alloc_refused++;
    endtask

    task automatic send_alloc(input logic [7:0] size);
        send_command(MODE_ALLOC, size, 8'($urandom));
    endtask

    task automatic send_free(input logic [7:0] offset);
        send_command(MODE_FREE, 8'($urandom), offset);
    endtask

    // Drop start between bursts; the argument sets the length of the gap.
    task automatic sender_gap(input int unsigned cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Every done pulse is one result transfer; it must match the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result transfer with nothing owed: data_offset=%0d failed=%0b",
                       result.data_offset, result.failed);
                error_count++;
            end
            else
            begin
                ffaa_out_t want;
                want = owed_results.pop_front();
                if (result.data_offset !== want.data_offset)
                begin
                    $error("data_offset: expected %0d, got %0d",
                           want.data_offset, result.data_offset);
                    error_count++;
                end
                if (result.failed !== want.failed)
                begin
                    $error("failed: expected %0b, got %0b", want.failed, result.failed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("first_fit_arena_allocator_unit_tb: errors");
            $finish;
        end
    end

    // Whole-block allocations, a refused request and a zero-byte request.
    task automatic test_single_block();
        send_alloc(8'd255);                       // larger than the only block: refused
        send_alloc(8'(ARENA_BYTES - HEADER_BYTES)); // exact fit, nothing to split
        send_alloc(8'd0);                         // arena exhausted
        send_free(8'(HEADER_BYTES));
        send_alloc(8'd0);                         // zero bytes, splits the rest off
        send_free(8'(HEADER_BYTES));              // merges back into one block
    endtask

    // Fill the table with zero-byte blocks until it can no longer split, then
    // release three of them so that the last one merges on both sides.
    task automatic test_full_table();
        for (int k = 0; k < MAX_BLOCKS; k++)
            send_alloc(8'd0);
        send_alloc(8'd1);                         // everything used: refused
        send_free(8'(HEADER_BYTES * 3));
        send_free(8'(HEADER_BYTES * 5));
        send_free(8'(HEADER_BYTES * 4));          // both neighbors available
        send_free(8'(HEADER_BYTES * 4));          // no longer a used block
        send_free(8'd255);
        send_free(8'd0);
        sender_gap(3);
    endtask

    // Mostly well-formed traffic: allocations of mostly small sizes and frees
    // of live blocks, with stray frees and oversized requests mixed in.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned burst;
        int unsigned pick;
        burst = $urandom_range(1, 12);
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_alloc(8'($urandom_range(0, 40)));
            else if (pick < 55)
                send_alloc(8'($urandom));
            else if (pick < 92)
                send_free(pick_live_offset());
            else
                send_free(8'($urandom));
            // Bursts of back-to-back commands with random gaps between them.
            if (--burst == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    sender_gap($urandom_range(1, 20));
                burst = $urandom_range(1, 12);
            end
        end
        sender_gap(1);
    endtask

    initial
    begin
        table_reset();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_single_block();
        test_full_table();
        test_random_traffic(950);

        // Drain: every owed result must arrive, then the bench waits out a quiet tail.
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (MAX_BLOCKS + 8) @(posedge clk);

        $display("covered %0d allocations (%0d refused, %0d unsplit with table full)",
                 alloc_sent, alloc_refused, table_full_seen);
        $display("and %0d frees over %0d cycles", free_sent, cycle_count);
        if (error_count == 0)
            $display("first_fit_arena_allocator_unit_tb: clean");
        else
            $display("first_fit_arena_allocator_unit_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
